// ----- hdl/mi3_pkg.sv -----
package mi3_pkg;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 32;
  localparam int FRAC_IN  = 8;
  localparam int FRAC_OUT = 16;
  localparam int N_ELEM   = 9;

  // cofactor, determinant and shifted numerator widths
  localparam int CW   = 2 * IN_W + 1;
  localparam int DW   = IN_W + CW + 2;
  localparam int NW   = CW + FRAC_IN + FRAC_OUT;
  localparam int XW   = ((NW > OUT_W) ? NW : OUT_W) + 1;
  localparam int FS   = 5;
  localparam int NSTG = FS + NW + 1;

  typedef struct packed {
    logic signed [IN_W-1:0] a_r0c0;
    logic signed [IN_W-1:0] a_r0c1;
    logic signed [IN_W-1:0] a_r0c2;
    logic signed [IN_W-1:0] a_r1c0;
    logic signed [IN_W-1:0] a_r1c1;
    logic signed [IN_W-1:0] a_r1c2;
    logic signed [IN_W-1:0] a_r2c0;
    logic signed [IN_W-1:0] a_r2c1;
    logic signed [IN_W-1:0] a_r2c2;
  } mi3_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] q_r0c0;
    logic signed [OUT_W-1:0] q_r0c1;
    logic signed [OUT_W-1:0] q_r0c2;
    logic signed [OUT_W-1:0] q_r1c0;
    logic signed [OUT_W-1:0] q_r1c1;
    logic signed [OUT_W-1:0] q_r1c2;
    logic signed [OUT_W-1:0] q_r2c0;
    logic signed [OUT_W-1:0] q_r2c1;
    logic signed [OUT_W-1:0] q_r2c2;
    logic                    singular;
    logic                    overflow;
  } mi3_out_t;

endpackage

// ----- hdl/mi3_front.sv -----
module mi3_front (
  input  logic                        clk_i,
  input  logic [mi3_pkg::FS-1:0]      en_i,
  input  mi3_pkg::mi3_in_t            a_i,
  output logic [mi3_pkg::CW-1:0]      cmag_o [mi3_pkg::N_ELEM],
  output logic                        neg_o  [mi3_pkg::N_ELEM],
  output logic [mi3_pkg::DW-1:0]      dmag_o,
  output logic                        zero_o
);
  import mi3_pkg::*;

  localparam int PW = 2 * IN_W;
  localparam int TW = IN_W + CW;

  logic signed [IN_W-1:0] a [9];
  logic signed [PW-1:0]   p_q [18];
  logic signed [IN_W-1:0] col1_q [3];
  logic signed [IN_W-1:0] col2_q [3];
  logic signed [CW-1:0]   c_q [9];
  logic signed [CW-1:0]   c3_q [9];
  logic signed [TW-1:0]   dp_q [3];
  logic signed [DW-1:0]   det_q;
  logic [CW-1:0]          cm_q [9];
  logic                   cn_q [9];
  logic [CW-1:0]          cm5_q [9];
  logic                   ng5_q [9];
  logic [DW-1:0]          dm_q;
  logic                   zr_q;

  assign a[0] = a_i.a_r0c0;
  assign a[1] = a_i.a_r0c1;
  assign a[2] = a_i.a_r0c2;
  assign a[3] = a_i.a_r1c0;
  assign a[4] = a_i.a_r1c1;
  assign a[5] = a_i.a_r1c2;
  assign a[6] = a_i.a_r2c0;
  assign a[7] = a_i.a_r2c1;
  assign a[8] = a_i.a_r2c2;

  // two products per cofactor, laid out as row-major cofactor pairs
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q[0]  <= a[4] * a[8];  p_q[1]  <= a[5] * a[7];  // c00
      p_q[2]  <= a[7] * a[2];  p_q[3]  <= a[1] * a[8];  // c01
      p_q[4]  <= a[1] * a[5];  p_q[5]  <= a[2] * a[4];  // c02
      p_q[6]  <= a[6] * a[5];  p_q[7]  <= a[3] * a[8];  // c10
      p_q[8]  <= a[0] * a[8];  p_q[9]  <= a[6] * a[2];  // c11
      p_q[10] <= a[2] * a[3];  p_q[11] <= a[0] * a[5];  // c12
      p_q[12] <= a[3] * a[7];  p_q[13] <= a[6] * a[4];  // c20
      p_q[14] <= a[1] * a[6];  p_q[15] <= a[0] * a[7];  // c21
      p_q[16] <= a[0] * a[4];  p_q[17] <= a[1] * a[3];  // c22
      col1_q[0] <= a[0];
      col1_q[1] <= a[3];
      col1_q[2] <= a[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 9; i++) begin
        c_q[i] <= CW'(p_q[2*i]) - CW'(p_q[2*i+1]);
      end
      col2_q <= col1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dp_q[0] <= col2_q[0] * c_q[0];
      dp_q[1] <= col2_q[1] * c_q[1];
      dp_q[2] <= col2_q[2] * c_q[2];
      c3_q    <= c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      det_q <= DW'(dp_q[0]) + DW'(dp_q[1]) + DW'(dp_q[2]);
      for (int i = 0; i < 9; i++) begin
        cn_q[i] <= c3_q[i][CW-1];
        cm_q[i] <= c3_q[i][CW-1] ? CW'(-c3_q[i]) : CW'(c3_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      zr_q <= (det_q == '0);
      dm_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      for (int i = 0; i < 9; i++) begin
        ng5_q[i] <= cn_q[i] ^ det_q[DW-1];
      end
      cm5_q <= cm_q;
    end
  end

  assign cmag_o = cm5_q;
  assign neg_o  = ng5_q;
  assign dmag_o = dm_q;
  assign zero_o = zr_q;

endmodule

// ----- hdl/mi3_div_lane.sv -----
module mi3_div_lane (
  input  logic                   clk_i,
  input  logic [mi3_pkg::NW-1:0] en_i,
  input  logic [mi3_pkg::CW-1:0] nmag_i,
  input  logic                   neg_i,
  input  logic [mi3_pkg::DW-1:0] div_i [mi3_pkg::NW],
  output logic [mi3_pkg::NW-1:0] q_o,
  output logic                   neg_o
);
  import mi3_pkg::*;

  localparam int SH = FRAC_IN + FRAC_OUT;

  logic [DW-1:0] r_q  [NW];
  logic [NW-1:0] nq_q [NW];
  logic          ng_q [NW];
  logic [DW-1:0] r_p  [NW];
  logic [NW-1:0] nq_p [NW];
  logic          ng_p [NW];
  logic [DW-1:0] r_d  [NW];
  logic [NW-1:0] nq_d [NW];

  // restoring division, one quotient bit per stage; numerator bits shift out
  // of the top of nq while quotient bits shift in at the bottom
  always_comb begin
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        r_p[k]  = '0;
        nq_p[k] = {nmag_i, {SH{1'b0}}};
        ng_p[k] = neg_i;
      end else begin
        r_p[k]  = r_q[k-1];
        nq_p[k] = nq_q[k-1];
        ng_p[k] = ng_q[k-1];
      end
      t       = {r_p[k], nq_p[k][NW-1]};
      diff    = t - {1'b0, div_i[k]};
      ge      = (t >= {1'b0, div_i[k]});
      r_d[k]  = ge ? diff[DW-1:0] : t[DW-1:0];
      nq_d[k] = {nq_p[k][NW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NW; k++) begin
      if (en_i[k]) begin
        r_q[k]  <= r_d[k];
        nq_q[k] <= nq_d[k];
        ng_q[k] <= ng_p[k];
      end
    end
  end

  assign q_o   = nq_q[NW-1];
  assign neg_o = ng_q[NW-1];

endmodule

// ----- hdl/matrix3x3_inverse.sv -----
// Inverse of a 3x3 matrix by the adjugate, one matrix per word.
// Input channel: in_valid_i / in_stall_o carry one word of nine signed Q8.8
// elements. Output channel: out_valid_o / out_stall_i carry nine signed
// Q16.16 elements of the inverse, plus singular and overflow flags.
// Of the NSTG pipeline stages, five front stages form products,
// cofactors and the determinant, then nine divider lanes resolve one
// quotient bit per stage over NW stages (the width of the shifted
// cofactor magnitude), and a final stage saturates and merges.
// Throughput is one word per cycle while the receiver does not stall.
// A singular matrix gives all-zero elements with singular set. Quotients
// are truncated toward zero and saturated; overflow is set if any lane
// saturated.
// Reset clears all valid bits; the pipeline is then empty and ready.
// When the receiver stalls, the output word holds and each stage holds
// only while the stage after it is full, so bubbles are squeezed out and
// new words are taken until the pipeline fills.
module matrix3x3_inverse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mi3_pkg::mi3_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mi3_pkg::mi3_out_t  out_data_o
);
  import mi3_pkg::*;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic [CW-1:0]   cmag [N_ELEM];
  logic            fneg [N_ELEM];
  logic [DW-1:0]   dmag;
  logic            zero;
  logic [DW-1:0]   dq_q [NW-1];
  logic            zq_q [NW];
  logic [DW-1:0]   div_in [NW];
  logic [NW-1:0]   lq [N_ELEM];
  logic            lneg [N_ELEM];
  logic [OUT_W-1:0] el_d [N_ELEM];
  logic [OUT_W-1:0] el_q [N_ELEM];
  logic            sat [N_ELEM];
  logic            ovf_d;
  logic            sing_q;
  logic            ovf_q;

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  mi3_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[FS-1:0]),
    .a_i    (in_data_i),
    .cmag_o (cmag),
    .neg_o  (fneg),
    .dmag_o (dmag),
    .zero_o (zero)
  );

  // divisor and singular flag travel beside the lanes
  always_ff @(posedge clk_i) begin
    if (en[FS]) begin
      dq_q[0] <= dmag;
      zq_q[0] <= zero;
    end
    for (int k = 1; k < NW - 1; k++) begin
      if (en[FS+k]) begin
        dq_q[k] <= dq_q[k-1];
      end
    end
    for (int k = 1; k < NW; k++) begin
      if (en[FS+k]) begin
        zq_q[k] <= zq_q[k-1];
      end
    end
  end

  always_comb begin
    div_in[0] = dmag;
    for (int k = 1; k < NW; k++) begin
      div_in[k] = dq_q[k-1];
    end
  end

  for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
    mi3_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[FS+NW-1:FS]),
      .nmag_i (cmag[i]),
      .neg_i  (fneg[i]),
      .div_i  (div_in),
      .q_o    (lq[i]),
      .neg_o  (lneg[i])
    );
  end

  // saturate each lane and merge flags
  always_comb begin
    logic [XW-1:0] qx;
    logic [XW-1:0] lim;
    logic [XW-1:0] nq;
    lim   = XW'(1) << (OUT_W - 1);
    ovf_d = 1'b0;
    for (int i = 0; i < N_ELEM; i++) begin
      qx = XW'(lq[i]);
      nq = ~qx + XW'(1);
      if (zq_q[NW-1]) begin
        sat[i]  = 1'b0;
        el_d[i] = '0;
      end else if (!lneg[i]) begin
        sat[i]  = (qx >= lim);
        el_d[i] = sat[i] ? {1'b0, {(OUT_W-1){1'b1}}} : qx[OUT_W-1:0];
      end else begin
        sat[i]  = (qx > lim);
        el_d[i] = sat[i] ? {1'b1, {(OUT_W-1){1'b0}}} : nq[OUT_W-1:0];
      end
      ovf_d = ovf_d | sat[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      el_q   <= el_d;
      sing_q <= zq_q[NW-1];
      ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o         = v_q[NSTG-1];
  assign out_data_o.q_r0c0   = el_q[0];
  assign out_data_o.q_r0c1   = el_q[1];
  assign out_data_o.q_r0c2   = el_q[2];
  assign out_data_o.q_r1c0   = el_q[3];
  assign out_data_o.q_r1c1   = el_q[4];
  assign out_data_o.q_r1c2   = el_q[5];
  assign out_data_o.q_r2c0   = el_q[6];
  assign out_data_o.q_r2c1   = el_q[7];
  assign out_data_o.q_r2c2   = el_q[8];
  assign out_data_o.singular = sing_q;
  assign out_data_o.overflow = ovf_q;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  a_sing_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |-> !out_data_o.overflow)
    else $error("overflow flagged on singular matrix");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.q_r0c0 == '0 && out_data_o.q_r1c1 == '0 &&
      out_data_o.q_r2c2 == '0 && out_data_o.q_r0c2 == '0)
    else $error("nonzero element on singular matrix");

endmodule

// ----- dv/matrix3x3_inverse_tb.sv -----
module matrix3x3_inverse_tb;
  import mi3_pkg::*;

  localparam int PIPE_DEPTH = NSTG;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 600;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  mi3_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  mi3_out_t out_data_o;

  matrix3x3_inverse dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  mi3_in_t  pending_mats[$];
  mi3_out_t expected_invs[$];
  int       send_idle_pct;
  int       stall_pct;
  int       hold_off_cycles;
  int       quiet_cycles;
  int       error_count;
  bit       stim_done;
  logic     accepted_any;
  logic     in_fire;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Exact adjugate inverse, truncated toward zero and saturated to OUT_W.
  function automatic mi3_out_t invert_matrix(mi3_in_t m);
    logic signed [127:0] a [3][3];
    logic signed [127:0] c [3][3];
    logic signed [127:0] det, num, quo, hi_lim, lo_lim;
    logic [OUT_W-1:0]    v [9];
    mi3_out_t            res;
    bit                  ovf;
    a[0][0] = m.a_r0c0; a[0][1] = m.a_r0c1; a[0][2] = m.a_r0c2;
    a[1][0] = m.a_r1c0; a[1][1] = m.a_r1c1; a[1][2] = m.a_r1c2;
    a[2][0] = m.a_r2c0; a[2][1] = m.a_r2c1; a[2][2] = m.a_r2c2;
    c[0][0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
    c[1][0] = a[2][0] * a[1][2] - a[1][0] * a[2][2];
    c[2][0] = a[1][0] * a[2][1] - a[2][0] * a[1][1];
    c[0][1] = a[2][1] * a[0][2] - a[0][1] * a[2][2];
    c[1][1] = a[0][0] * a[2][2] - a[2][0] * a[0][2];
    c[2][1] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
    c[0][2] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
    c[1][2] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
    c[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
    det = a[0][0] * c[0][0] + a[1][0] * c[0][1] + a[2][0] * c[0][2];
    res = '0;
    ovf = 1'b0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    hi_lim = (128'sd1 <<< (OUT_W - 1)) - 1;
    lo_lim = -(128'sd1 <<< (OUT_W - 1));
    for (int i = 0; i < 9; i++) begin
      num = c[i / 3][i % 3] <<< (FRAC_IN + FRAC_OUT);
      quo = num / det;  // signed division truncates toward zero
      if (quo > hi_lim) begin
        quo = hi_lim;
        ovf = 1'b1;
      end else if (quo < lo_lim) begin
        quo = lo_lim;
        ovf = 1'b1;
      end
      v[i] = quo[OUT_W-1:0];
    end
    res.q_r0c0 = v[0]; res.q_r0c1 = v[1]; res.q_r0c2 = v[2];
    res.q_r1c0 = v[3]; res.q_r1c1 = v[4]; res.q_r1c2 = v[5];
    res.q_r2c0 = v[6]; res.q_r2c1 = v[7]; res.q_r2c2 = v[8];
    res.overflow = ovf;
    return res;
  endfunction

  function automatic mi3_in_t mat_from(logic signed [IN_W-1:0] e [9]);
    mi3_in_t m;
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  function automatic logic signed [IN_W-1:0] rand_elem(int mode);
    logic signed [IN_W-1:0] r;
    case (mode)
      0: r = IN_W'($urandom);
      1: r = IN_W'($signed($urandom_range(0, 1024)) - 512);
      2: r = IN_W'($signed($urandom_range(0, 16)) - 8);
      default: r = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    endcase
    return r;
  endfunction

  task automatic queue_directed();
    logic signed [IN_W-1:0] e [9];
    // identity, diagonal and scaled identity, full-scale extremes
    e = '{16'sd256, 0, 0, 0, 16'sd256, 0, 0, 0, 16'sd256};
    pending_mats.push_back(mat_from(e));
    e = '{16'sd512, 0, 0, 0, -16'sd128, 0, 0, 0, 16'sd64};
    pending_mats.push_back(mat_from(e));
    e = '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
    pending_mats.push_back(mat_from(e));
    e = '{-16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
    pending_mats.push_back(mat_from(e));
    e = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff};
    pending_mats.push_back(mat_from(e));
    e = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
    pending_mats.push_back(mat_from(e));
    e = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
    pending_mats.push_back(mat_from(e));
    e = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    pending_mats.push_back(mat_from(e));
    // singular: zero matrix, repeated row, rank one of all -1 and of extremes
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    pending_mats.push_back(mat_from(e));
    e = '{16'sd3, 16'sd5, 16'sd7, 16'sd3, 16'sd5, 16'sd7, 16'sd1, 16'sd2, 16'sd9};
    pending_mats.push_back(mat_from(e));
    e = '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
          -16'sd1, -16'sd1, -16'sd1};
    pending_mats.push_back(mat_from(e));
    e = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh8000};
    pending_mats.push_back(mat_from(e));
    // near-singular: det of one unit, big cofactors saturate both ways
    e = '{16'sd1, 16'sd1, 0, 0, 16'sd1, 16'sd1, 0, 0, 16'sd1};
    pending_mats.push_back(mat_from(e));
    e = '{16'sd1000, 16'sd999, 0, 16'sd999, 16'sd998, 0, 0, 0, 16'sd1};
    pending_mats.push_back(mat_from(e));
    e = '{16'sd1000, -16'sd999, 0, -16'sd999, 16'sd998, 0, 0, 0, -16'sd1};
    pending_mats.push_back(mat_from(e));
    // permutation
    e = '{0, 16'sd256, 0, 0, 0, 16'sd256, 16'sd256, 0, 0};
    pending_mats.push_back(mat_from(e));
  endtask

  task automatic queue_random(int count);
    logic signed [IN_W-1:0] e [9];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        e[i] = rand_elem((mode < 4) ? 0 : (mode < 6) ? 1 : (mode < 8) ? 2 : 3);
      end
      // force some singular words by copying a row
      if ($urandom_range(0, 9) == 0) begin
        e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end
      pending_mats.push_back(mat_from(e));
    end
  endtask

  task automatic wait_drained();
    while (expected_invs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // note whether the input word was taken at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
    end
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_fire) begin
      if (pending_mats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_mats.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_stall_i     <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: record accepted words, check results
  always @(posedge clk_i) begin
    mi3_out_t exp_inv;
    if (rst_ni) begin
      accepted_any = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        expected_invs.push_back(invert_matrix(in_data_i));
        accepted_any = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        accepted_any = 1'b1;
        if (expected_invs.size() == 0) begin
          $error("unexpected output word %h", out_data_o);
          error_count++;
        end else begin
          exp_inv = expected_invs.pop_front();
          if (out_data_o.q_r0c0 !== exp_inv.q_r0c0) begin
            $error("q_r0c0 exp %h got %h", exp_inv.q_r0c0, out_data_o.q_r0c0);
            error_count++;
          end
          if (out_data_o.q_r0c1 !== exp_inv.q_r0c1) begin
            $error("q_r0c1 exp %h got %h", exp_inv.q_r0c1, out_data_o.q_r0c1);
            error_count++;
          end
          if (out_data_o.q_r0c2 !== exp_inv.q_r0c2) begin
            $error("q_r0c2 exp %h got %h", exp_inv.q_r0c2, out_data_o.q_r0c2);
            error_count++;
          end
          if (out_data_o.q_r1c0 !== exp_inv.q_r1c0) begin
            $error("q_r1c0 exp %h got %h", exp_inv.q_r1c0, out_data_o.q_r1c0);
            error_count++;
          end
          if (out_data_o.q_r1c1 !== exp_inv.q_r1c1) begin
            $error("q_r1c1 exp %h got %h", exp_inv.q_r1c1, out_data_o.q_r1c1);
            error_count++;
          end
          if (out_data_o.q_r1c2 !== exp_inv.q_r1c2) begin
            $error("q_r1c2 exp %h got %h", exp_inv.q_r1c2, out_data_o.q_r1c2);
            error_count++;
          end
          if (out_data_o.q_r2c0 !== exp_inv.q_r2c0) begin
            $error("q_r2c0 exp %h got %h", exp_inv.q_r2c0, out_data_o.q_r2c0);
            error_count++;
          end
          if (out_data_o.q_r2c1 !== exp_inv.q_r2c1) begin
            $error("q_r2c1 exp %h got %h", exp_inv.q_r2c1, out_data_o.q_r2c1);
            error_count++;
          end
          if (out_data_o.q_r2c2 !== exp_inv.q_r2c2) begin
            $error("q_r2c2 exp %h got %h", exp_inv.q_r2c2, out_data_o.q_r2c2);
            error_count++;
          end
          if (out_data_o.singular !== exp_inv.singular) begin
            $error("singular exp %b got %b", exp_inv.singular, out_data_o.singular);
            error_count++;
          end
          if (out_data_o.overflow !== exp_inv.overflow) begin
            $error("overflow exp %b got %b", exp_inv.overflow, out_data_o.overflow);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles = accepted_any ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("matrix3x3_inverse regression: fail");
        $finish;
      end else if (stim_done) begin
        if (error_count == 0) begin
          $display("matrix3x3_inverse regression: pass");
        end else begin
          $display("matrix3x3_inverse regression: fail");
        end
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_stall_i     = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_cycles = 0;
    quiet_cycles    = 0;
    error_count     = 0;
    stim_done       = 1'b0;
    accepted_any    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni = 1'b1;

    queue_directed();
    queue_random(100);
    while (pending_mats.size() != 0) @(posedge clk_i);
    wait_drained();

    send_idle_pct = 77;
    queue_random(120);
    while (pending_mats.size() != 0) @(posedge clk_i);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 77;
    queue_random(120);
    while (pending_mats.size() != 0) @(posedge clk_i);
    wait_drained();

    send_idle_pct = 33;
    stall_pct     = 33;
    queue_random(120);
    while (pending_mats.size() != 0) @(posedge clk_i);
    wait_drained();

    // long receiver hold-off so the pipeline fills and stalls its input
    send_idle_pct = 0;
    stall_pct     = 0;
    @(negedge clk_i);
    hold_off_cycles = 3 * PIPE_DEPTH;
    queue_random(140);
    while (pending_mats.size() != 0) @(posedge clk_i);
    wait_drained();

    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    stim_done = 1'b1;
  end

endmodule
